### hw/rtl/swrc_pkg.sv
// ----------------------------------------------------------------------------
// swrc_pkg
// Shared types and codes for the stack with read cursor.
// ----------------------------------------------------------------------------
package swrc_pkg;

  localparam int OPCODE_W = 3;
  localparam int PUSH_W   = 32;
  localparam int STATUS_W = 2;
  localparam int READ_W   = 32;
  localparam int LEVEL_W  = 7;
  localparam int WIDE_W   = 64;

  // Operation codes carried by a request.
  localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_NEXT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PREV  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PUSH_W-1:0]   push_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [READ_W-1:0]   read_value;
    logic [LEVEL_W-1:0]  level;
  } rsp_t;

  // Everything about an operation except the memory read data, held
  // between the pointer stage and the result stage.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  level;
    logic                use_rd;
  } stage_t;

endpackage

### hw/rtl/swrc_core.sv
// ----------------------------------------------------------------------------
// swrc_core
// Pointer update, entry memory and the registered first stage.
// ----------------------------------------------------------------------------
module swrc_core
  import swrc_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  input  logic                  adv,
  output logic                  s1_valid,
  output stage_t                s1,
  output logic [DATA_WIDTH-1:0] rdata
);

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PW-1:0] top;
  logic [PW-1:0] top_next;
  logic [PW-1:0] cursor;
  logic [PW-1:0] cursor_next;
  logic [PW-1:0] raddr_full;
  logic [STATUS_W-1:0] status;
  logic          we;
  logic          re;
  logic          accept;

  assign req_stall = s1_valid && !adv;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    top_next    = top;
    cursor_next = cursor;
    raddr_full  = cursor;
    status      = ST_OK;
    we          = 1'b0;
    re          = 1'b0;
    unique case (req.opcode)
      OP_PUSH: begin
        if (top == PW'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          we       = 1'b1;
          top_next = top + 1'b1;
        end
      end
      OP_POP: begin
        if (top == '0) begin
          status = ST_EMPTY;
        end else begin
          // The cursor may not stand above the new top.
          if (cursor == top) begin
            cursor_next = cursor - 1'b1;
          end
          top_next   = top - 1'b1;
          raddr_full = top - 1'b1;
          re         = 1'b1;
        end
      end
      OP_CLEAR: begin
        top_next    = '0;
        cursor_next = '0;
      end
      OP_NEXT: begin
        if (cursor >= top) begin
          status = ST_EMPTY;
        end else begin
          raddr_full  = cursor;
          cursor_next = cursor + 1'b1;
          re          = 1'b1;
        end
      end
      OP_PREV: begin
        if (cursor == '0) begin
          status = ST_EMPTY;
        end else begin
          cursor_next = cursor - 1'b1;
          raddr_full  = cursor - 1'b1;
          re          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top      <= '0;
      cursor   <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        top    <= top_next;
        cursor <= cursor_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.status <= status;
      s1.level  <= LEVEL_W'(top_next);
      s1.use_rd <= re;
    end
  end

  // A push writes at the old top; reads only ever address entries below
  // the top, so the read and write of one operation never collide.
  always_ff @(posedge clk) begin
    if (accept && we) begin
      mem[top[AW-1:0]] <= DATA_WIDTH'(WIDE_W'(req.push_value));
    end
    if (accept && re) begin
      rdata <= mem[raddr_full[AW-1:0]];
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= top)
    else $error("cursor above top of stack");

  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    top <= PW'(DEPTH))
    else $error("stack level above capacity");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1))
    else $error("first stage changed while blocked");

  a_pop_lowers_top: assert property (@(posedge clk) disable iff (rst)
    accept && req.opcode == OP_POP && top != '0 |=> top == $past(top) - 1'b1)
    else $error("pop did not lower the stack level");

endmodule

### hw/rtl/swrc_out.sv
// ----------------------------------------------------------------------------
// swrc_out
// Result register: forms the response and holds it while stalled.
// ----------------------------------------------------------------------------
module swrc_out
  import swrc_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s1_valid,
  input  stage_t                s1,
  input  logic [DATA_WIDTH-1:0] rdata,
  output logic                  adv,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp
);

  logic [WIDE_W-1:0] wide;
  logic              load;

  assign wide = WIDE_W'(rdata);
  assign adv  = s1_valid && (!rsp_valid || !rsp_stall);
  assign load = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status     <= s1.status;
      rsp.level      <= s1.level;
      rsp.read_value <= s1.use_rd ? wide[READ_W-1:0] : '0;
    end
  end

endmodule

### hw/rtl/stack_with_read_cursor.sv
// ----------------------------------------------------------------------------
// stack_with_read_cursor
// LIFO stack of fixed capacity with a separate read cursor.
// ----------------------------------------------------------------------------
//
//   channel | ports                       | payload
//   --------+-----------------------------+---------------------------------
//   request | req_valid, req_stall, req   | opcode, push_value
//   result  | rsp_valid, rsp_stall, rsp   | status, read_value, level
//
// One request is taken every cycle while req_stall is low. The accepting
// edge updates the top and cursor pointers and does at most one memory
// access; the response is registered when the first stage advances.
// Reset clears the pointers and both valid flags; the entry memory is not
// cleared, since entries are only read after they have been written.
// A stalled result holds in the output register while one more request
// sits in the first stage; beyond that the request side stalls.
//
module stack_with_read_cursor
  import swrc_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // First stage: status, level and a flag telling whether the read data
  // carries the returned entry.
  logic                  s1_valid;
  stage_t                s1;
  logic [DATA_WIDTH-1:0] rdata;

  // High when the first stage moves into the result register.
  logic                  adv;

  swrc_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .rdata     (rdata)
  );

  // The result register zeroes read_value for operations that return no
  // entry and trims the entry to the result field width.
  swrc_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .rdata     (rdata),
    .adv       (adv),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
